// ----- src/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Item kinds, wildcard byte codes and the queued op type.
// ----------------------------------------------------------------------------
package wpm_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  localparam logic [7:0] CH_ANY_ONE = 8'd63;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'd42;  // '*'
  localparam logic [7:0] CH_NUL     = 8'd0;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
  } op_t;

endpackage

// ----- src/wpm_front.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher front end
// Accepts input beats, drops NUL appends and hands ops to the queue.
// ----------------------------------------------------------------------------
module wpm_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  input  logic [7:0]      character_i,
  output logic            push_o,
  input  logic            push_ready_i,
  output wpm_pkg::op_t    push_op_o
);

  wpm_pkg::kind_e kind;
  logic           nul_append;

  assign kind       = wpm_pkg::kind_e'(kind_i);
  // A NUL pattern byte is taken, but has no effect.
  assign nul_append = (kind == wpm_pkg::KIND_APPEND) && (character_i == wpm_pkg::CH_NUL);

  assign in_ready_o     = push_ready_i;
  assign push_o         = in_valid_i && push_ready_i && !nul_append;
  assign push_op_o.kind = kind;
  assign push_op_o.chr  = character_i;

endmodule

// ----- src/wpm_fifo.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher op queue
// Short FIFO between front end and match engine.
// ----------------------------------------------------------------------------
module wpm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  wpm_pkg::op_t    push_op_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output wpm_pkg::op_t    pop_op_o
);

  localparam int unsigned PtrW = $clog2(wpm_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(wpm_pkg::QUEUE_DEPTH + 1);

  wpm_pkg::op_t    mem_q [wpm_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(wpm_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(wpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(wpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(wpm_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(wpm_pkg::QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- src/wpm_back.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher engine
// Pattern cells, reachable position set and the result register.
// ----------------------------------------------------------------------------
module wpm_back #(
  parameter int unsigned MaxPattern = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  output logic            op_ready_o,
  input  wpm_pkg::op_t    op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            matched_o,
  output logic            overflow_o
);

  localparam int unsigned W    = MaxPattern + 1;  // positions 0..MaxPattern
  localparam int unsigned LenW = $clog2(W);
  localparam int unsigned Lvl  = $clog2(W);

  // Pattern cells
  logic [7:0]      byte_q [MaxPattern];
  logic            star_q [MaxPattern];
  logic            any_q  [MaxPattern];
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [W-1:0]    reach_q, reach_d;

  logic            out_valid_q, out_valid_d;
  logic            matched_q, overflow_q;

  logic            pop, is_clear, is_append, is_text, is_end, room;
  logic [W-1:0]    live, star_v, closed, stay, adv, next_set;
  logic [W-1:0]    gen  [Lvl+1];
  logic [W-1:0]    prop [Lvl+1];

  assign is_clear  = (op_i.kind == wpm_pkg::KIND_CLEAR);
  assign is_append = (op_i.kind == wpm_pkg::KIND_APPEND);
  assign is_text   = (op_i.kind == wpm_pkg::KIND_TEXT);
  assign is_end    = (op_i.kind == wpm_pkg::KIND_END);

  // Only end-of-text beats need the result slot.
  assign op_ready_o = !is_end || !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;
  assign room       = (len_q < LenW'(MaxPattern));

  always_comb begin
    live   = '0;
    star_v = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      live[i]   = (LenW'(i) < len_q);
      star_v[i] = live[i] && star_q[i];
    end
  end

  // Star closure as a parallel prefix: a set position on a '*' carries to the next.
  always_comb begin
    gen[0]  = reach_q;
    prop[0] = {star_v[W-2:0], 1'b0};
    for (int l = 0; l < Lvl; l++) begin
      for (int i = 0; i < W; i++) begin
        if (i >= (1 << l)) begin
          gen[l+1][i]  = gen[l][i] | (prop[l][i] & gen[l][i-(1<<l)]);
          prop[l+1][i] = prop[l][i] & prop[l][i-(1<<l)];
        end else begin
          gen[l+1][i]  = gen[l][i];
          prop[l+1][i] = prop[l][i];
        end
      end
    end
    closed = gen[Lvl];
  end

  always_comb begin
    stay = '0;
    adv  = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      if (closed[i] && live[i]) begin
        if (star_q[i]) begin
          stay[i] = 1'b1;
        end else if (any_q[i] || byte_q[i] == op_i.chr) begin
          adv[i] = 1'b1;
        end
      end
    end
    next_set = stay | {adv[W-2:0], 1'b0};
  end

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    reach_d     = reach_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop) begin
      case (op_i.kind)
        wpm_pkg::KIND_CLEAR: begin
          len_d   = '0;
          ovf_d   = 1'b0;
          reach_d = W'(1);
        end
        wpm_pkg::KIND_APPEND: begin
          if (room) begin
            len_d = len_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          reach_d = W'(1);
        end
        wpm_pkg::KIND_TEXT: begin
          reach_d = next_set;
        end
        default: begin
          reach_d     = W'(1);
          out_valid_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      reach_q     <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      reach_q     <= reach_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && is_end) begin
      matched_q  <= closed[len_q];
      overflow_q <= ovf_q;
    end
    for (int i = 0; i < MaxPattern; i++) begin
      if (pop && is_append && room && len_q == LenW'(i)) begin
        byte_q[i] <= op_i.chr;
        star_q[i] <= (op_i.chr == wpm_pkg::CH_ANY_RUN);
        any_q[i]  <= (op_i.chr == wpm_pkg::CH_ANY_ONE);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (is_end || is_clear || is_append)) |=> (reach_q == W'(1)))
    else $error("matcher not rearmed");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxPattern))
    else $error("pattern length beyond capacity");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_end) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  a_text_keeps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_text) |=> (len_q == $past(len_q)))
    else $error("text beat changed pattern length");

endmodule

// ----- src/wildcard_pattern_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher unit
// Whole-string '?'/'*' matcher: pattern loads beat by beat, text streams in,
// end of text returns the match verdict and the sticky overflow flag.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------
//   in      | in  | in_valid_i/in_ready_o  | kind_i[1:0], character_i[7:0]
//   out     | out | out_valid_o/out_ready_i| matched_o, overflow_o
//
// One beat per cycle while no result waits untaken; every position of the
// pattern updates in the same cycle by the engine's prefix-tree star closure.
// End-of-text result is registered first in the queue, then in the engine.
// Reset needs no clearing pass; the pattern cells are simply unwritten.
// in_ready_o drops only when the two-entry queue is full; the engine holds an
// end-of-text beat only while the previous result is still not taken.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_unit #(
  parameter int unsigned MAX_PATTERN = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       overflow_o
);

  logic         push, push_ready, pop_valid, pop_ready;
  wpm_pkg::op_t push_op, pop_op;

  wpm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .character_i  (character_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  wpm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  wpm_back #(
    .MaxPattern (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (pop_valid),
    .op_ready_o  (pop_ready),
    .op_i        (pop_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .matched_o   (matched_o),
    .overflow_o  (overflow_o)
  );

endmodule
